// ===== src/yaw_pitch_view_matrix_defines.svh =====
// ----------------------------------------------------------------------------
// yaw_pitch_view_matrix_defines
// assertion macros shared by the checker of the view matrix block
// ----------------------------------------------------------------------------
`ifndef YAW_PITCH_VIEW_MATRIX_DEFINES_SVH
`define YAW_PITCH_VIEW_MATRIX_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define YPVM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ypvm check failed");

// next-cycle implication, sampled on clk, off during reset
`define YPVM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ypvm check failed");

`endif

// ===== src/ypvm_pkg.sv =====
// ----------------------------------------------------------------------------
// ypvm_pkg
// types, constants and tables of the yaw/pitch view matrix block
// ----------------------------------------------------------------------------
package ypvm_pkg;

  // cordic iteration count and arctangent table length
  localparam int CORDIC_STEPS = 16;
  localparam int TAB_LEN      = 24;
  localparam int NSTEP        = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
  localparam int STEP_W       = $clog2(TAB_LEN + 1);

  // field widths
  localparam int YAW_W   = 25;
  localparam int PIT_W   = 24;
  localparam int ZOOM_W  = 15;
  localparam int EYE_W   = 24;
  localparam int SENS_W  = 16;
  localparam int OFS_W   = 12;
  localparam int STEPZ_W = 8;
  localparam int COL_W   = 16;
  localparam int TRN_W   = 26;
  localparam int PROD_W  = OFS_W + SENS_W + 1;
  localparam int SUM_W   = 30;
  localparam int CX_W    = 34;
  localparam int CZ_W    = 26;
  localparam int MUL_W   = COL_W + EYE_W;
  localparam int ACC_W   = 42;
  localparam int DOT_W   = ACC_W - 14;

  // register indexes
  localparam logic [1:0] REG_EYE_X = 2'd0;
  localparam logic [1:0] REG_EYE_Y = 2'd1;
  localparam logic [1:0] REG_EYE_Z = 2'd2;
  localparam logic [1:0] REG_SENS  = 2'd3;

  // operation codes
  localparam logic OP_LOOK = 1'b0;
  localparam logic OP_ZOOM = 1'b1;

  // angle constants in Q.16 degrees
  localparam logic signed [SUM_W-1:0] DEG180_S   = 30'sd11796480;
  localparam logic signed [SUM_W-1:0] NDEG180_S  = -30'sd11796480;
  localparam logic signed [SUM_W-1:0] DEG360_S   = 30'sd23592960;
  localparam logic signed [SUM_W-1:0] PITCH_MAX  = 30'sd5898239;
  localparam logic signed [SUM_W-1:0] PITCH_MIN  = -30'sd5898239;
  localparam logic signed [CZ_W-1:0]  DEG90_Z    = 26'sd5898240;
  localparam logic signed [CZ_W-1:0]  NDEG90_Z   = -26'sd5898240;
  localparam logic signed [CZ_W-1:0]  DEG180_Z   = 26'sd11796480;

  // zoom limits in Q7.8
  localparam logic [ZOOM_W-1:0] ZOOM_MIN = 15'd256;
  localparam logic [ZOOM_W-1:0] ZOOM_MAX = 15'd23039;

  // reset values
  localparam logic signed [YAW_W-1:0] YAW_RST  = -25'sd5898240;
  localparam logic [ZOOM_W-1:0]       ZOOM_RST = 15'd11520;
  localparam logic signed [EYE_W-1:0] EYEZ_RST = 24'sd51200;
  localparam logic [SENS_W-1:0]       SENS_RST = 16'd6554;

  // cordic gain in Q2.30
  localparam logic signed [CX_W-1:0] GAIN_Q30 = 34'sd652032874;

  // camera angles handed from front to back
  typedef struct packed {
    logic signed [YAW_W-1:0] yaw;
    logic signed [PIT_W-1:0] pitch;
    logic [ZOOM_W-1:0]       zoom;
  } ypvm_view_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } ypvm_q_stat_t;

  typedef enum logic [2:0] {F_IDLE, F_ADD, F_WRAP, F_PUSH} front_state_t;
  typedef enum logic [2:0] {B_IDLE, B_ROT, B_MUL, B_DOT, B_OUT} back_state_t;

  // arctangent of 2^-i in Q.16 degrees
  function automatic logic [21:0] atan_q16(input logic [STEP_W-1:0] i);
    logic [21:0] v;
    unique case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/ypvm_if.sv =====
// ----------------------------------------------------------------------------
// ypvm_in_if / ypvm_out_if
// valid/ready channels for events and view matrix rows
// ----------------------------------------------------------------------------
interface ypvm_in_if;
  logic              valid;
  logic              ready;
  logic              op;
  logic signed [11:0] x_offset;
  logic signed [11:0] y_offset;
  logic signed [7:0]  zoom_step;

  modport source (output valid, op, x_offset, y_offset, zoom_step, input ready);
  modport sink   (input valid, op, x_offset, y_offset, zoom_step, output ready);
endinterface

interface ypvm_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         row;
  logic signed [15:0] col0;
  logic signed [15:0] col1;
  logic signed [15:0] col2;
  logic signed [25:0] translation;
  logic [14:0]        zoom_angle;
  logic               last;

  modport source (output valid, row, col0, col1, col2, translation, zoom_angle, last,
                  input ready);
  modport sink   (input valid, row, col0, col1, col2, translation, zoom_angle, last,
                  output ready);
endinterface

// ===== src/ypvm_front.sv =====
// ----------------------------------------------------------------------------
// ypvm_front
// takes events, updates yaw, pitch and zoom, queues the new camera angles
// ----------------------------------------------------------------------------
module ypvm_front (
  input  logic                     clk,
  input  logic                     rst_n,
  ypvm_in_if.sink                  in_itf,
  input  logic [15:0]              sens,
  input  ypvm_pkg::ypvm_q_stat_t   q_stat,
  output logic                     push,
  output ypvm_pkg::ypvm_view_t     push_data
);
  import ypvm_pkg::*;

  front_state_t               state_r, state_nxt;
  logic signed [YAW_W-1:0]    yaw_r, yaw_nxt;
  logic signed [PIT_W-1:0]    pitch_r, pitch_nxt;
  logic [ZOOM_W-1:0]          zoom_r, zoom_nxt;
  logic signed [PROD_W-1:0]   px_r, px_nxt, py_r, py_nxt;
  logic signed [SUM_W-1:0]    t_r, t_nxt;

  logic signed [PROD_W-1:0]   px_prod, py_prod;
  logic signed [SUM_W-1:0]    p_sum;
  logic signed [17:0]         z_sum;
  logic signed [17:0]         z_clip;

  // mouse offsets scaled by sensitivity
  assign px_prod = in_itf.x_offset * $signed({1'b0, sens});
  assign py_prod = in_itf.y_offset * $signed({1'b0, sens});
  assign p_sum   = SUM_W'(pitch_r) + SUM_W'(py_r);

  // zoom step in whole degrees, applied only inside the legal range
  always_comb begin
    if (zoom_r >= ZOOM_MIN && zoom_r <= ZOOM_MAX) begin
      z_sum = $signed({3'b000, zoom_r}) - (18'(in_itf.zoom_step) <<< 8);
    end else begin
      z_sum = $signed({3'b000, zoom_r});
    end
    if (z_sum < $signed({3'b000, ZOOM_MIN})) begin
      z_clip = $signed({3'b000, ZOOM_MIN});
    end else if (z_sum > $signed({3'b000, ZOOM_MAX})) begin
      z_clip = $signed({3'b000, ZOOM_MAX});
    end else begin
      z_clip = z_sum;
    end
  end

  assign in_itf.ready = (state_r == F_IDLE);
  assign push_data    = '{yaw: yaw_r, pitch: pitch_r, zoom: zoom_r};

  // next state and datapath
  always_comb begin
    state_nxt = state_r;
    yaw_nxt   = yaw_r;
    pitch_nxt = pitch_r;
    zoom_nxt  = zoom_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    t_nxt     = t_r;
    push      = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        if (in_itf.valid) begin
          if (in_itf.op == OP_ZOOM) begin
            zoom_nxt  = ZOOM_W'(z_clip);
            state_nxt = F_PUSH;
          end else begin
            px_nxt    = px_prod;
            py_nxt    = py_prod;
            state_nxt = F_ADD;
          end
        end
      end
      F_ADD: begin
        t_nxt = SUM_W'(yaw_r) + SUM_W'(px_r) + DEG180_S - DEG180_S;
        if (p_sum > PITCH_MAX) begin
          pitch_nxt = PIT_W'(PITCH_MAX);
        end else if (p_sum < PITCH_MIN) begin
          pitch_nxt = PIT_W'(PITCH_MIN);
        end else begin
          pitch_nxt = PIT_W'(p_sum);
        end
        state_nxt = F_WRAP;
      end
      F_WRAP: begin
        // one turn per cycle until yaw lies in [-180, 180)
        if (t_r >= DEG180_S) begin
          t_nxt = t_r - DEG360_S;
        end else if (t_r < NDEG180_S) begin
          t_nxt = t_r + DEG360_S;
        end else begin
          yaw_nxt   = YAW_W'(t_r);
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_stat.full) begin
          push      = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      yaw_r   <= YAW_RST;
      pitch_r <= '0;
      zoom_r  <= ZOOM_RST;
    end else begin
      state_r <= state_nxt;
      yaw_r   <= yaw_nxt;
      pitch_r <= pitch_nxt;
      zoom_r  <= zoom_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r <= px_nxt;
    py_r <= py_nxt;
    t_r  <= t_nxt;
  end

endmodule

// ===== src/ypvm_queue.sv =====
// ----------------------------------------------------------------------------
// ypvm_queue
// two-entry queue of camera angles between front and back
// ----------------------------------------------------------------------------
module ypvm_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  ypvm_pkg::ypvm_view_t     push_data,
  input  logic                     pop,
  output ypvm_pkg::ypvm_view_t     pop_data,
  output ypvm_pkg::ypvm_q_stat_t   q_stat
);
  import ypvm_pkg::*;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  ypvm_view_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wptr_r, rptr_r;
  logic [QPTR_W:0]    cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_data     = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

// ===== src/ypvm_back.sv =====
// ----------------------------------------------------------------------------
// ypvm_back
// cordic sin/cos, shared multiplier and row output of the view matrix
// ----------------------------------------------------------------------------
module ypvm_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ypvm_pkg::ypvm_q_stat_t   q_stat,
  input  ypvm_pkg::ypvm_view_t     pop_data,
  output logic                     pop,
  input  logic signed [23:0]       eye_x,
  input  logic signed [23:0]       eye_y,
  input  logic signed [23:0]       eye_z,
  ypvm_out_if.source               out_itf
);
  import ypvm_pkg::*;

  back_state_t               state_r, state_nxt;
  logic                      sel_r, sel_nxt;
  logic signed [PIT_W-1:0]   pit_r, pit_nxt;
  logic [ZOOM_W-1:0]         zoom_r, zoom_nxt;
  logic signed [CX_W-1:0]    rx_r, rx_nxt, ry_r, ry_nxt;
  logic signed [CZ_W-1:0]    rz_r, rz_nxt;
  logic                      neg_r, neg_nxt;
  logic [STEP_W-1:0]         it_r, it_nxt;
  logic signed [COL_W-1:0]   sin_y_r, sin_y_nxt, cos_y_r, cos_y_nxt;
  logic signed [COL_W-1:0]   sin_p_r, sin_p_nxt, cos_p_r, cos_p_nxt;
  logic signed [COL_W-1:0]   fx_r, fx_nxt, fz_r, fz_nxt, ux_r, ux_nxt, uz_r, uz_nxt;
  logic [1:0]                cnt_r, cnt_nxt, row_r, row_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;

  logic                      ov_r, ov_nxt;
  logic [1:0]                o_row_r, o_row_nxt;
  logic signed [COL_W-1:0]   o_c0_r, o_c0_nxt, o_c1_r, o_c1_nxt, o_c2_r, o_c2_nxt;
  logic signed [TRN_W-1:0]   o_tr_r, o_tr_nxt;
  logic [ZOOM_W-1:0]         o_zm_r, o_zm_nxt;
  logic                      o_last_r, o_last_nxt;

  logic signed [CZ_W-1:0]    ld_ang, ld_z;
  logic                      ld_neg;
  logic signed [CX_W-1:0]    dx, dy, xr, yr;
  logic signed [CZ_W-1:0]    atan_s;
  logic signed [COL_W-1:0]   xq, yq;
  logic signed [COL_W-1:0]   mul_a;
  logic signed [EYE_W-1:0]   mul_b;
  logic signed [MUL_W-1:0]   prod, prod_rnd;
  logic signed [COL_W-1:0]   m14;
  logic signed [COL_W-1:0]   coef;
  logic signed [EYE_W-1:0]   eye_sel;
  logic signed [DOT_W-1:0]   dot, dot_s;
  logic signed [TRN_W-1:0]   trn;
  logic                      out_free;

  // angle to rotate: yaw from the queue, or the held pitch
  assign ld_ang = (state_r == B_IDLE) ? CZ_W'(pop_data.yaw) : CZ_W'(pit_r);

  // fold angles beyond +-90 degrees by a half turn
  always_comb begin
    ld_neg = 1'b0;
    ld_z   = ld_ang;
    if (ld_ang > DEG90_Z) begin
      ld_z   = ld_ang - DEG180_Z;
      ld_neg = 1'b1;
    end else if (ld_ang < NDEG90_Z) begin
      ld_z   = ld_ang + DEG180_Z;
      ld_neg = 1'b1;
    end
  end

  // one cordic micro-rotation
  assign dx     = ry_r >>> it_r;
  assign dy     = rx_r >>> it_r;
  assign atan_s = $signed({{(CZ_W-22){1'b0}}, atan_q16(it_r)});

  // round the cordic outputs to Q1.14 and clamp to +-1.0
  assign xr = (rx_r + CX_W'(32768)) >>> 16;
  assign yr = (ry_r + CX_W'(32768)) >>> 16;
  always_comb begin
    if (xr > CX_W'(16384)) begin
      xq = 16'sd16384;
    end else if (xr < -CX_W'(16384)) begin
      xq = -16'sd16384;
    end else begin
      xq = COL_W'(xr);
    end
    if (yr > CX_W'(16384)) begin
      yq = 16'sd16384;
    end else if (yr < -CX_W'(16384)) begin
      yq = -16'sd16384;
    end else begin
      yq = COL_W'(yr);
    end
    if (neg_r) begin
      xq = -xq;
      yq = -yq;
    end
  end

  // dot-product coefficient and eye component for this row and term
  always_comb begin
    coef = '0;
    unique case (row_r)
      2'd0: begin
        unique case (cnt_r)
          2'd0:    coef = -sin_y_r;
          2'd2:    coef = cos_y_r;
          default: coef = '0;
        endcase
      end
      2'd1: begin
        unique case (cnt_r)
          2'd0:    coef = ux_r;
          2'd1:    coef = cos_p_r;
          default: coef = uz_r;
        endcase
      end
      default: begin
        unique case (cnt_r)
          2'd0:    coef = fx_r;
          2'd1:    coef = sin_p_r;
          default: coef = fz_r;
        endcase
      end
    endcase
    unique case (cnt_r)
      2'd0:    eye_sel = eye_x;
      2'd1:    eye_sel = eye_y;
      default: eye_sel = eye_z;
    endcase
  end

  // shared multiplier: Q1.14 products, then dot-product terms
  always_comb begin
    if (state_r == B_MUL) begin
      unique case (cnt_r)
        2'd0: begin mul_a = cos_p_r; mul_b = EYE_W'(cos_y_r); end
        2'd1: begin mul_a = cos_p_r; mul_b = EYE_W'(sin_y_r); end
        2'd2: begin mul_a = cos_y_r; mul_b = EYE_W'(sin_p_r); end
        default: begin mul_a = sin_y_r; mul_b = EYE_W'(sin_p_r); end
      endcase
    end else begin
      mul_a = coef;
      mul_b = eye_sel;
    end
  end
  assign prod     = mul_a * mul_b;
  assign prod_rnd = (prod + MUL_W'(8192)) >>> 14;
  assign m14      = COL_W'(prod_rnd);

  // translation: round to Q.8, sign by row, saturate
  assign dot   = DOT_W'((acc_r + ACC_W'(8192)) >>> 14);
  assign dot_s = (row_r == 2'd2) ? dot : -dot;
  always_comb begin
    if (dot_s > DOT_W'(33554431)) begin
      trn = 26'sd33554431;
    end else if (dot_s < -DOT_W'(33554432)) begin
      trn = -26'sd33554432;
    end else begin
      trn = TRN_W'(dot_s);
    end
  end

  assign out_free = !ov_r || out_itf.ready;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    sel_nxt    = sel_r;
    pit_nxt    = pit_r;
    zoom_nxt   = zoom_r;
    rx_nxt     = rx_r;
    ry_nxt     = ry_r;
    rz_nxt     = rz_r;
    neg_nxt    = neg_r;
    it_nxt     = it_r;
    sin_y_nxt  = sin_y_r;
    cos_y_nxt  = cos_y_r;
    sin_p_nxt  = sin_p_r;
    cos_p_nxt  = cos_p_r;
    fx_nxt     = fx_r;
    fz_nxt     = fz_r;
    ux_nxt     = ux_r;
    uz_nxt     = uz_r;
    cnt_nxt    = cnt_r;
    row_nxt    = row_r;
    acc_nxt    = acc_r;
    pop        = 1'b0;
    ov_nxt     = ov_r && !out_itf.ready;
    o_row_nxt  = o_row_r;
    o_c0_nxt   = o_c0_r;
    o_c1_nxt   = o_c1_r;
    o_c2_nxt   = o_c2_r;
    o_tr_nxt   = o_tr_r;
    o_zm_nxt   = o_zm_r;
    o_last_nxt = o_last_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          pit_nxt   = pop_data.pitch;
          zoom_nxt  = pop_data.zoom;
          sel_nxt   = 1'b0;
          rx_nxt    = GAIN_Q30;
          ry_nxt    = '0;
          rz_nxt    = ld_z;
          neg_nxt   = ld_neg;
          it_nxt    = '0;
          state_nxt = B_ROT;
        end
      end
      B_ROT: begin
        if (it_r == STEP_W'(NSTEP)) begin
          if (!sel_r) begin
            sin_y_nxt = yq;
            cos_y_nxt = xq;
            sel_nxt   = 1'b1;
            rx_nxt    = GAIN_Q30;
            ry_nxt    = '0;
            rz_nxt    = ld_z;
            neg_nxt   = ld_neg;
            it_nxt    = '0;
          end else begin
            sin_p_nxt = yq;
            cos_p_nxt = xq;
            cnt_nxt   = '0;
            state_nxt = B_MUL;
          end
        end else begin
          if (!rz_r[CZ_W-1]) begin
            rx_nxt = rx_r - dx;
            ry_nxt = ry_r + dy;
            rz_nxt = rz_r - atan_s;
          end else begin
            rx_nxt = rx_r + dx;
            ry_nxt = ry_r - dy;
            rz_nxt = rz_r + atan_s;
          end
          it_nxt = it_r + 1'b1;
        end
      end
      B_MUL: begin
        unique case (cnt_r)
          2'd0:    fx_nxt = m14;
          2'd1:    fz_nxt = m14;
          2'd2:    ux_nxt = -m14;
          default: uz_nxt = -m14;
        endcase
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 2'd3) begin
          cnt_nxt   = '0;
          row_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = B_DOT;
        end
      end
      B_DOT: begin
        acc_nxt = acc_r + ACC_W'(prod);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 2'd2) begin
          cnt_nxt   = '0;
          state_nxt = B_OUT;
        end
      end
      B_OUT: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          o_row_nxt  = row_r;
          o_tr_nxt   = trn;
          o_zm_nxt   = zoom_r;
          o_last_nxt = (row_r == 2'd2);
          unique case (row_r)
            2'd0: begin
              o_c0_nxt = -sin_y_r;
              o_c1_nxt = '0;
              o_c2_nxt = cos_y_r;
            end
            2'd1: begin
              o_c0_nxt = ux_r;
              o_c1_nxt = cos_p_r;
              o_c2_nxt = uz_r;
            end
            default: begin
              o_c0_nxt = -fx_r;
              o_c1_nxt = -sin_p_r;
              o_c2_nxt = -fz_r;
            end
          endcase
          acc_nxt = '0;
          if (row_r == 2'd2) begin
            state_nxt = B_IDLE;
          end else begin
            row_nxt   = row_r + 1'b1;
            state_nxt = B_DOT;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
      sel_r   <= 1'b0;
      it_r    <= '0;
      cnt_r   <= '0;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      sel_r   <= sel_nxt;
      it_r    <= it_nxt;
      cnt_r   <= cnt_nxt;
      row_r   <= row_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pit_r    <= pit_nxt;
    zoom_r   <= zoom_nxt;
    rx_r     <= rx_nxt;
    ry_r     <= ry_nxt;
    rz_r     <= rz_nxt;
    neg_r    <= neg_nxt;
    sin_y_r  <= sin_y_nxt;
    cos_y_r  <= cos_y_nxt;
    sin_p_r  <= sin_p_nxt;
    cos_p_r  <= cos_p_nxt;
    fx_r     <= fx_nxt;
    fz_r     <= fz_nxt;
    ux_r     <= ux_nxt;
    uz_r     <= uz_nxt;
    acc_r    <= acc_nxt;
    o_row_r  <= o_row_nxt;
    o_c0_r   <= o_c0_nxt;
    o_c1_r   <= o_c1_nxt;
    o_c2_r   <= o_c2_nxt;
    o_tr_r   <= o_tr_nxt;
    o_zm_r   <= o_zm_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_itf.valid       = ov_r;
  assign out_itf.row         = o_row_r;
  assign out_itf.col0        = o_c0_r;
  assign out_itf.col1        = o_c1_r;
  assign out_itf.col2        = o_c2_r;
  assign out_itf.translation = o_tr_r;
  assign out_itf.zoom_angle  = o_zm_r;
  assign out_itf.last        = o_last_r;

endmodule

// ===== src/yaw_pitch_view_matrix.sv =====
// ----------------------------------------------------------------------------
// yaw_pitch_view_matrix
// euler-angle camera producing look-at view matrix rows
// ----------------------------------------------------------------------------
// Each look or zoom event yields three row transfers (rows 0, 1, 2, last on
// row 2). The front passes a zoom through its idle and push states, a look
// also through its add and wrap states, the wrap removing one full turn at a
// time, and hands the angles through a two-entry queue. The back works on
// one event at a time with its single iterative CORDIC unit, used for yaw
// and then pitch, and its one shared 16x24 multiplier. Eye and sensitivity
// writes apply to events that follow them.
module yaw_pitch_view_matrix (
  input  logic         clk,
  input  logic         rst_n,
  ypvm_in_if.sink      in_itf,
  ypvm_out_if.source   out_itf,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_idx,
  input  logic [23:0]  cfg_wdata
);
  import ypvm_pkg::*;

  logic signed [EYE_W-1:0] eye_x_r, eye_y_r, eye_z_r;
  logic [SENS_W-1:0]       sens_r;
  ypvm_q_stat_t            q_stat;
  ypvm_view_t              push_data, pop_data;
  logic                    push, pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eye_x_r <= '0;
      eye_y_r <= '0;
      eye_z_r <= EYEZ_RST;
      sens_r  <= SENS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_EYE_X: eye_x_r <= cfg_wdata;
        REG_EYE_Y: eye_y_r <= cfg_wdata;
        REG_EYE_Z: eye_z_r <= cfg_wdata;
        REG_SENS:  sens_r  <= cfg_wdata[SENS_W-1:0];
        default:   ;
      endcase
    end
  end

  ypvm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_itf    (in_itf),
    .sens      (sens_r),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  ypvm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  ypvm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .pop_data (pop_data),
    .pop      (pop),
    .eye_x    (eye_x_r),
    .eye_y    (eye_y_r),
    .eye_z    (eye_z_r),
    .out_itf  (out_itf)
  );

endmodule

// ===== src/ypvm_checker.sv =====
// ----------------------------------------------------------------------------
// ypvm_checker
// port-level checks of the view matrix row stream
// ----------------------------------------------------------------------------
`include "yaw_pitch_view_matrix_defines.svh"

module ypvm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  row,
  input logic [15:0] col1,
  input logic [25:0] translation,
  input logic [14:0] zoom_angle,
  input logic        last
);

  // a stalled row keeps its translation
  `YPVM_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(translation))

  // last marks row 2 and only row 2
  `YPVM_ASSERT_NOW(a_last_row, out_valid, last == (row == 2'd2))

  // the right axis has no y component
  `YPVM_ASSERT_NOW(a_row0_col1, out_valid && row == 2'd0, col1 == 16'd0)

  // zoom angle stays in its clamp range
  `YPVM_ASSERT_NOW(a_zoom_rng, out_valid, zoom_angle >= 15'd256 && zoom_angle <= 15'd23039)

endmodule

bind yaw_pitch_view_matrix ypvm_checker u_ypvm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_itf.valid),
  .out_ready   (out_itf.ready),
  .row         (out_itf.row),
  .col1        (out_itf.col1),
  .translation (out_itf.translation),
  .zoom_angle  (out_itf.zoom_angle),
  .last        (out_itf.last)
);

// ===== tb/sv/tb_yaw_pitch_view_matrix.sv =====
// ----------------------------------------------------------------------------
// tb_yaw_pitch_view_matrix
// self-checking bench for the euler-angle camera: look and zoom events are
// sent with random gaps, each event's three view matrix rows are predicted in
// fixed point and compared field by field against the row transfers
// ----------------------------------------------------------------------------
module tb_yaw_pitch_view_matrix;
  import ypvm_pkg::*;

  localparam int  DRAIN_CYCLES = 80;
  localparam longint CYCLE_LIMIT = 600000;
  localparam longint Q_DEG90  = 5898240;
  localparam longint Q_DEG180 = 11796480;
  localparam longint Q_DEG360 = 23592960;
  localparam longint Q_PITCH_LIM = 5898239;

  typedef struct packed {
    logic [1:0]  row;
    logic [15:0] col0;
    logic [15:0] col1;
    logic [15:0] col2;
    logic [25:0] translation;
    logic [14:0] zoom_angle;
    logic        last;
  } view_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [23:0] cfg_wdata;

  ypvm_in_if  in_itf();
  ypvm_out_if out_itf();

  yaw_pitch_view_matrix dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_itf    (in_itf.sink),
    .out_itf   (out_itf.source),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // camera shadow state
  longint cam_eye_x, cam_eye_y, cam_eye_z, cam_sens;
  longint cam_yaw, cam_pitch, cam_zoom;
  view_row_t pending_rows[$];
  int mismatches;
  longint cycles;

  // arctangent of 2^-i in Q.16 degrees
  longint atan_tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                           29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                           57, 29, 14, 7, 4, 2, 1, 0};

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // cycle counter and timeout
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_yaw_pitch_view_matrix NOT OK");
      $finish;
    end
  end

  function automatic longint clamp_l(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // rotation-mode cordic, results rounded to Q1.14
  function automatic void sin_cos_q14(input longint ang, output longint s_o,
                                      output longint c_o);
    longint x, y, z, dx, dy;
    bit flip;
    x = 652032874;
    y = 0;
    flip = 0;
    if (ang > Q_DEG90) begin
      ang -= Q_DEG180;
      flip = 1;
    end else if (ang < -Q_DEG90) begin
      ang += Q_DEG180;
      flip = 1;
    end
    z = ang;
    for (int i = 0; i < NSTEP; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    x = clamp_l((x + 32768) >>> 16, -16384, 16384);
    y = clamp_l((y + 32768) >>> 16, -16384, 16384);
    c_o = flip ? -x : x;
    s_o = flip ? -y : y;
  endfunction

  function automatic longint mul_q14(longint a, longint b);
    return (a * b + 8192) >>> 14;
  endfunction

  function automatic longint eye_dot(longint a, longint b, longint c, bit neg);
    longint d;
    d = (a * cam_eye_x + b * cam_eye_y + c * cam_eye_z + 8192) >>> 14;
    if (neg) d = -d;
    return clamp_l(d, -33554432, 33554431);
  endfunction

  // advance the camera by one event and queue its three rows
  task automatic predict_view(input logic op, input logic signed [11:0] xo,
                              input logic signed [11:0] yo,
                              input logic signed [7:0] zs);
    longint t, sy, cy, sp, cp, fx, fy, fz, ux, uy, uz;
    longint m[3][4];
    view_row_t r;
    if (op == OP_LOOK) begin
      t = cam_yaw + longint'(xo) * cam_sens + Q_DEG180;
      t = t % Q_DEG360;
      if (t < 0) t += Q_DEG360;
      cam_yaw = t - Q_DEG180;
      cam_pitch = clamp_l(cam_pitch + longint'(yo) * cam_sens, -Q_PITCH_LIM, Q_PITCH_LIM);
    end else begin
      t = cam_zoom;
      if (t >= 256 && t <= 23039) t -= longint'(zs) * 256;
      cam_zoom = clamp_l(t, 256, 23039);
    end
    sin_cos_q14(cam_yaw, sy, cy);
    sin_cos_q14(cam_pitch, sp, cp);
    fx = mul_q14(cp, cy); fy = sp; fz = mul_q14(cp, sy);
    ux = -mul_q14(cy, sp); uy = cp; uz = -mul_q14(sy, sp);
    m[0][0] = -sy; m[0][1] = 0;   m[0][2] = cy;  m[0][3] = eye_dot(-sy, 0, cy, 1);
    m[1][0] = ux;  m[1][1] = uy;  m[1][2] = uz;  m[1][3] = eye_dot(ux, uy, uz, 1);
    m[2][0] = -fx; m[2][1] = -fy; m[2][2] = -fz; m[2][3] = eye_dot(fx, fy, fz, 0);
    for (int i = 0; i < 3; i++) begin
      r.row = i[1:0];
      r.col0 = m[i][0][15:0];
      r.col1 = m[i][1][15:0];
      r.col2 = m[i][2][15:0];
      r.translation = m[i][3][25:0];
      r.zoom_angle = cam_zoom[14:0];
      r.last = (i == 2);
      pending_rows.push_back(r);
    end
  endtask

  // row checker
  always @(posedge clk) begin
    view_row_t got, want;
    if (rst_n && out_itf.valid && out_itf.ready) begin
      got = '{out_itf.row, out_itf.col0, out_itf.col1, out_itf.col2,
              out_itf.translation, out_itf.zoom_angle, out_itf.last};
      if (pending_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected row transfer: %p", got);
      end else begin
        want = pending_rows.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("row mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  function automatic int rand_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // result side stalls
  initial out_itf.ready = 1'b0;
  always @(negedge clk) begin
    int stall;
    if (!rst_n) begin
      out_itf.ready = 1'b0;
    end else if (stall > 0) begin
      stall--;
      out_itf.ready = 1'b0;
    end else begin
      out_itf.ready = 1'b1;
      if ($urandom_range(0, 3) == 0) stall = rand_gap();
    end
  end

  // send one event and wait for its transfer
  task automatic send_event(input logic op, input logic signed [11:0] xo,
                            input logic signed [11:0] yo, input logic signed [7:0] zs);
    int gap;
    @(negedge clk);
    in_itf.valid = 1'b1;
    in_itf.op = op;
    in_itf.x_offset = xo;
    in_itf.y_offset = yo;
    in_itf.zoom_step = zs;
    do @(posedge clk); while (!in_itf.ready);
    predict_view(op, xo, yo, zs);
    gap = rand_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_itf.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_rows();
    @(negedge clk);
    in_itf.valid = 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input longint val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = val[23:0];
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_EYE_X: cam_eye_x = longint'($signed(val[23:0]));
      REG_EYE_Y: cam_eye_y = longint'($signed(val[23:0]));
      REG_EYE_Z: cam_eye_z = longint'($signed(val[23:0]));
      default:   cam_sens = longint'(val[15:0]);
    endcase
  endtask

  task automatic set_camera(input longint ex, input longint ey, input longint ez,
                            input longint sens);
    write_reg(REG_EYE_X, ex);
    write_reg(REG_EYE_Y, ey);
    write_reg(REG_EYE_Z, ez);
    write_reg(REG_SENS, sens);
  endtask

  // defaults, field extremes, pitch saturation and zoom clamps
  task automatic test_directed_events();
    send_event(OP_ZOOM, 12'sd0, 12'sd0, 8'sd0);
    send_event(OP_LOOK, 12'sd0, 12'sd0, 8'sd0);
    send_event(OP_LOOK, 12'sd2047, 12'sd0, -8'sd128);
    send_event(OP_LOOK, -12'sd2048, 12'sd0, 8'sd127);
    send_event(OP_LOOK, 12'sd0, 12'sd2047, 8'sd0);
    send_event(OP_LOOK, 12'sd0, 12'sd2047, 8'sd0);
    send_event(OP_LOOK, 12'sd100, -12'sd2048, 8'sd0);
    send_event(OP_LOOK, 12'sd0, -12'sd2048, 8'sd0);
    send_event(OP_ZOOM, 12'sd2047, -12'sd2048, 8'sd127);
    send_event(OP_ZOOM, -12'sd1, 12'sd1, 8'sd1);
    send_event(OP_ZOOM, 12'sd0, 12'sd0, -8'sd128);
    send_event(OP_ZOOM, 12'sd0, 12'sd0, -8'sd128);
    send_event(OP_ZOOM, 12'sd0, 12'sd0, 8'sd45);
    send_event(OP_ZOOM, 12'sd0, 12'sd0, -8'sd1);
    send_event(OP_LOOK, 12'sd900, 12'sd450, 8'sd0);
    send_event(OP_LOOK, -12'sd1800, -12'sd900, 8'sd0);
  endtask

  // eye and sensitivity extremes, written while idle
  task automatic test_config_extremes();
    drain_rows();
    set_camera(8388607, 8388607, 8388607, 65535);
    for (int i = 0; i < 6; i++)
      send_event(i % 3 == 2, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                 8'($urandom_range(0, 255)));
    drain_rows();
    set_camera(-8388608, -8388608, -8388608, 0);
    for (int i = 0; i < 4; i++)
      send_event(OP_LOOK, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                 8'sd0);
    drain_rows();
    set_camera(8388607, -8388608, 0, 1);
    send_event(OP_LOOK, 12'sd2047, 12'sd2047, 8'sd0);
    send_event(OP_LOOK, -12'sd2048, -12'sd2048, 8'sd0);
  endtask

  // random events under three random camera settings and the reset defaults
  task automatic test_random_events();
    for (int ph = 0; ph < 4; ph++) begin
      drain_rows();
      if (ph == 3) set_camera(0, 0, 51200, 6554);
      else set_camera(longint'($urandom_range(0, 24'hFFFFFF)),
                      longint'($urandom_range(0, 24'hFFFFFF)),
                      longint'($urandom_range(0, 24'hFFFFFF)),
                      longint'($urandom_range(0, 16'hFFFF)));
      for (int i = 0; i < 33; i++) begin
        // hold the sender until the block has caught up
        if (i == 16) drain_rows();
        send_event($urandom_range(0, 3) == 0, 12'($urandom_range(0, 4095)),
                   12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_EYE_X;
    cfg_wdata = '0;
    in_itf.valid = 1'b0;
    in_itf.op = OP_LOOK;
    in_itf.x_offset = '0;
    in_itf.y_offset = '0;
    in_itf.zoom_step = '0;
    mismatches = 0;
    cam_eye_x = 0; cam_eye_y = 0; cam_eye_z = 51200; cam_sens = 6554;
    cam_yaw = -Q_DEG90; cam_pitch = 0; cam_zoom = 11520;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_directed_events();
    test_config_extremes();
    test_random_events();
    drain_rows();

    if (mismatches == 0 && pending_rows.size() == 0)
      $display("tb_yaw_pitch_view_matrix OK");
    else
      $display("tb_yaw_pitch_view_matrix NOT OK");
    $finish;
  end

endmodule

// ===== yaw_pitch_view_matrix.f =====
+incdir+src
src/ypvm_pkg.sv
src/ypvm_if.sv
src/ypvm_front.sv
src/ypvm_queue.sv
src/ypvm_back.sv
src/yaw_pitch_view_matrix.sv
src/ypvm_checker.sv
tb/sv/tb_yaw_pitch_view_matrix.sv
